/* rtl/core/stc_pkg.sv */
// stc_pkg: types and constants shared by the space-run-to-tab compressor.
// No dependencies.
`timescale 1ns / 1ps

package stc_pkg;

   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic       KIND_CHAR   = 1'b0;
   localparam logic       KIND_STATUS = 1'b1;
   localparam logic [31:0] STATUS_EMPTY = 32'hFFFF_FFFF;
   localparam logic [30:0] TAB_LIMIT    = 31'h7FFF_FFFF;
   localparam logic [6:0]  GROUP_MAX    = 7'd64;

   // stream state carried between transactions
   typedef struct packed {
      logic [5:0]  pending;
      logic [30:0] tabs;
      logic        seen;
      logic        stopped;
   } stream_state_type;

   // work left over from one input transaction: a run of spaces, then one item
   typedef struct packed {
      logic        valid;
      logic [5:0]  spaces;
      logic        kind;
      logic [7:0]  data_byte;
      logic [31:0] status;
   } job_type;

endpackage

/* rtl/core/stc_step.sv */
// stc_step: single-pass decode of one input transaction into the next stream
// state and the job of results it causes. Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_step (
   input  stc_pkg::stream_state_type state,
   input  logic [6:0]                group_size,
   input  logic [7:0]                in_byte,
   input  logic                      end_of_input,
   output stc_pkg::stream_state_type state_next,
   output stc_pkg::job_type          job
);
   import stc_pkg::*;

   logic [6:0]  run_count;
   logic [31:0] status_now;

   assign run_count  = {1'b0, state.pending} + 7'd1;
   assign status_now = state.seen ? {1'b0, state.tabs} : STATUS_EMPTY;

   always_comb begin
      state_next     = state;
      job.valid      = 1'b0;
      job.spaces     = 6'd0;
      job.kind       = KIND_CHAR;
      job.data_byte  = 8'd0;
      job.status     = 32'd0;
      if (!state.stopped) begin
         if (end_of_input) begin
            job.valid          = 1'b1;
            job.spaces         = state.pending;
            job.kind           = KIND_STATUS;
            job.status         = status_now;
            state_next.pending = 6'd0;
            state_next.tabs    = 31'd0;
            state_next.seen    = 1'b0;
         end else if (in_byte[7]) begin
            // non-ASCII counts as a byte, so the status is never the empty code
            job.valid          = 1'b1;
            job.spaces         = state.pending;
            job.kind           = KIND_STATUS;
            job.status         = {1'b0, state.tabs};
            state_next.pending = 6'd0;
            state_next.seen    = 1'b1;
            state_next.stopped = 1'b1;
         end else if (in_byte == CH_SPACE) begin
            state_next.seen = 1'b1;
            if (run_count >= group_size) begin
               job.valid          = 1'b1;
               job.data_byte      = CH_TAB;
               state_next.pending = 6'd0;
               if (state.tabs != TAB_LIMIT) begin
                  state_next.tabs = state.tabs + 31'd1;
               end
            end else begin
               state_next.pending = run_count[5:0];
            end
         end else begin
            job.valid          = 1'b1;
            job.spaces         = state.pending;
            job.data_byte      = in_byte;
            state_next.pending = 6'd0;
            state_next.seen    = 1'b1;
         end
      end
   end

endmodule

/* rtl/core/space_run_to_tab_compressor_unit.sv */
// The first result comes in the cycle after the input transaction; a byte that
// ends a run of N pending spaces gives N+1 results, one per unstalled cycle.
// Throughput: one input per cycle with no flush or output stall; a flush holds
// req_tready low until the job register has emitted all but its last result.
// Reset (synchronous): clears stream state, halt flag and job; group size 4.
`timescale 1ns / 1ps

module space_run_to_tab_compressor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [39:8] final_status
   output logic        rsp_tuser,   // item_kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // spaces_per_tab
);
   import stc_pkg::*;

   logic [6:0]       group_ff, group_in;
   logic [6:0]       group_size;
   stream_state_type state_ff, state_in, state_step;
   job_type          job_ff, job_in, job_step;
   logic             req_fire, rsp_fire, job_on_last;

   assign job_on_last = (job_ff.spaces == 6'd0);
   assign req_tready  = !job_ff.valid || (rsp_tready && job_on_last);
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_fire    = rsp_tvalid && rsp_tready;

   always_comb begin
      if (group_ff == 7'd0) begin
         group_size = 7'd1;
      end else if (group_ff > GROUP_MAX) begin
         group_size = GROUP_MAX;
      end else begin
         group_size = group_ff;
      end
   end

   stc_step u_step (
      .state        (state_ff),
      .group_size   (group_size),
      .in_byte      (req_tdata),
      .end_of_input (req_tlast),
      .state_next   (state_step),
      .job          (job_step)
   );

   always_comb begin
      group_in = csr_wr_en ? csr_wr_data : group_ff;
      state_in = req_fire ? state_step : state_ff;
      job_in   = job_ff;
      if (rsp_fire) begin
         if (job_on_last) begin
            job_in.valid = 1'b0;
         end else begin
            job_in.spaces = job_ff.spaces - 6'd1;
         end
      end
      if (req_fire) begin
         job_in = job_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= 7'd4;
         state_ff <= '0;
         job_ff   <= '0;
      end else begin
         group_ff <= group_in;
         state_ff <= state_in;
         job_ff   <= job_in;
      end
   end

   // leading spaces of a flush first, then the job's own item
   assign rsp_tvalid = job_ff.valid;
   assign rsp_tdata  = job_on_last ? {job_ff.status, job_ff.data_byte}
                                   : {32'd0, CH_SPACE};
   assign rsp_tuser  = job_on_last ? job_ff.kind : KIND_CHAR;
   assign rsp_tlast  = job_on_last;

endmodule

/* rtl/core/stc_checker.sv */
// stc_checker: port-level assertions for the compressor, bound to the top.
// Depends on space_run_to_tab_compressor_unit.
`timescale 1ns / 1ps

module stc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // a status always closes its burst and carries no byte
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[7:0] == 8'd0))
      else $error("status result not last or byte not zero");

   // only flushed spaces come before the last result of a burst
   a_flush_space: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !rsp_tuser && (rsp_tdata == 40'h20))
      else $error("non-space result inside a flush");

   // input is held off mid-burst
   a_no_accept_mid_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input ready during a flush");

endmodule

bind space_run_to_tab_compressor_unit stc_checker u_stc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
